// ----- hdl/sschunt_pkg.sv -----
// Shared types and constants for the static sync column detector.
// No dependencies; imported by every module of the block.
package sschunt_pkg;

   // Bit history covers positions 0 .. 7*16.
   localparam int HIST_W     = 113;
   localparam int HIST_IDX_W = $clog2(HIST_W);
   localparam int COLS_W     = 5;
   localparam int NUM_COUNTS = 8;
   localparam int SYNC_W     = 8;
   localparam logic [SYNC_W-1:0] SYNC_BYTE = 8'hB1;
   localparam logic [COLS_W-1:0] NO_MATCH  = '0;
   localparam logic [COLS_W-1:0] MAX_COLS  = 5'd16;

   typedef logic [HIST_W-1:0] hist_type;
   typedef logic [COLS_W-1:0] cols_type;

   // History stage contents handed to the matcher.
   typedef struct packed {
      logic     valid;
      hist_type bits;
   } hist_stage_type;

   // Samples the history every cols bits, newest bit as the LSB.
   function automatic logic [SYNC_W-1:0] sample_hist(input hist_type h, input int cols);
      logic [SYNC_W-1:0]     s;
      logic [HIST_IDX_W-1:0] pos;
      s = '0;
      for (int k = 0; k < SYNC_W; k++) begin
         pos  = HIST_IDX_W'(k*cols);
         s[k] = h[pos];
      end
      return s;
   endfunction

endpackage

// ----- hdl/static_sync_column_hunter.sv -----
// Top level of the static sync column detector: history stage, matcher,
// and the column mode register. Depends on sschunt_pkg, sschunt_hist, sschunt_match.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/ready    | req_line_bit (1 bit)
//   rsp     | out       | rsp_valid/ready    | rsp_matched_columns (5 bits)
//   csr     | in        | csr_valid/ready    | csr_column_mode (5 bits)
//
// One bit is taken per cycle while rsp is not stalled; its result passes through the
// history register and then the result register before it is offered on rsp.
// The history register and the result register form a two-entry pipeline,
// so a stalled result still lets one more bit into the history stage.
// Synchronous reset clears the history to zeros, the column mode to zero,
// and both valid flags. The csr port is always ready.
module static_sync_column_hunter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_line_bit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sschunt_pkg::cols_type rsp_matched_columns,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  sschunt_pkg::cols_type csr_column_mode
);
   import sschunt_pkg::*;

   cols_type       mode_ff, mode_in;
   hist_stage_type stage;
   logic           advance;

   // Column mode register, written by a csr transfer.
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_column_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= NO_MATCH;
      end else begin
         mode_ff <= mode_in;
      end
   end

   sschunt_hist u_hist (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_line_bit (req_line_bit),
      .advance      (advance),
      .stage        (stage)
   );

   sschunt_match u_match (
      .clock               (clock),
      .reset               (reset),
      .stage               (stage),
      .column_mode         (mode_ff),
      .advance             (advance),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_matched_columns (rsp_matched_columns)
   );

endmodule

// ----- hdl/sschunt_hist.sv -----
// Input stage: bit history shift register and its valid flag.
// Depends on sschunt_pkg.
module sschunt_hist (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_line_bit,
   input  logic                   advance,
   output sschunt_pkg::hist_stage_type stage
);
   import sschunt_pkg::*;

   logic     valid_ff, valid_in;
   hist_type hist_ff, hist_in;
   logic     take;

   // The stage takes a transfer when it is empty or its item moves on.
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   // Shift the new bit in at position 0; the oldest bit drops off.
   always_comb begin
      hist_in  = take ? {hist_ff[HIST_W-2:0], req_line_bit} : hist_ff;
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hist_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         hist_ff  <= hist_in;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.bits  = hist_ff;

   // An accepted transfer always leaves a valid item in the stage.
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> valid_ff)
      else $error("history stage empty after a transfer");

   // The history only moves when a bit is taken.
   a_hist_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(hist_ff))
      else $error("history changed without a transfer");

   // Moving an item on requires one to be present.
   a_adv_valid: assert property (@(posedge clock) disable iff (reset)
      advance |-> valid_ff)
      else $error("advance without a valid history item");

endmodule

// ----- hdl/sschunt_match.sv -----
// Sync byte matcher over all even column counts and the result register.
// Depends on sschunt_pkg.
module sschunt_match (
   input  logic                        clock,
   input  logic                        reset,
   input  sschunt_pkg::hist_stage_type stage,
   input  sschunt_pkg::cols_type       column_mode,
   output logic                        advance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sschunt_pkg::cols_type       rsp_matched_columns
);
   import sschunt_pkg::*;

   logic [NUM_COUNTS-1:0] hit;
   cols_type              search_cols;
   cols_type              result;
   logic [2:0]            mode_idx;
   logic                  mode_ok;
   logic                  valid_ff, valid_in;
   cols_type              cols_ff, cols_in;

   // One comparator per even column count 2..16.
   always_comb begin
      for (int i = 0; i < NUM_COUNTS; i++) begin
         hit[i] = (sample_hist(stage.bits, 2*(i+1)) == SYNC_BYTE);
      end
   end

   // Lowest matching count wins in search mode.
   always_comb begin
      search_cols = NO_MATCH;
      for (int i = NUM_COUNTS-1; i >= 0; i--) begin
         if (hit[i]) begin
            search_cols = COLS_W'(2*(i+1));
         end
      end
   end

   // A fixed mode must be even and within 2..16, otherwise it never matches.
   // A mode of sixteen wraps around to the last comparator.
   always_comb begin
      mode_idx = column_mode[3:1] - 3'd1;
      mode_ok  = !column_mode[0] && (column_mode <= MAX_COLS);
      if (column_mode == NO_MATCH) begin
         result = search_cols;
      end else if (mode_ok && hit[mode_idx]) begin
         result = column_mode;
      end else begin
         result = NO_MATCH;
      end
   end

   // Result register: loads whenever the history stage holds an item and it is empty or being drained.
   assign advance = stage.valid && (!valid_ff || rsp_ready);

   always_comb begin
      cols_in  = advance ? result : cols_ff;
      valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cols_ff <= cols_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_matched_columns = cols_ff;

   // Every reported count is even.
   a_even: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !cols_ff[0])
      else $error("odd column count reported");

   // Reported counts never exceed sixteen.
   a_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cols_ff <= MAX_COLS))
      else $error("column count out of range");

   // An item moved on from the history stage shows up as a result.
   a_adv_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> valid_ff)
      else $error("result register empty after load");

endmodule
